// File: src/uvst_pkg.sv
// ----------------------------------------------------------------------------
// uvst_pkg
// Types and codes shared by the ordered value set table and its cells.
// ----------------------------------------------------------------------------
package uvst_pkg;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_QUERY  = 2'd2;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_IGNORED = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] value;
	} uvst_req_t;

	typedef struct packed {
		logic       was_present;
		logic [3:0] position;
		logic [1:0] status;
		logic [4:0] entry_count;
	} uvst_rsp_t;

	// broadcast to every cell
	typedef struct packed {
		logic load;       // latch compare result for a new request
		logic insert_en;  // append at slot == count
		logic remove_en;  // slots at or above the hit take their neighbor
	} uvst_cell_ctl_t;

endpackage

// File: src/uvst_cell.sv
// ----------------------------------------------------------------------------
// uvst_cell
// One table slot: holds a value, compares it against a lookup key and
// shifts in its upper neighbor's value when its own entry or one below it is removed.
// ----------------------------------------------------------------------------
module uvst_cell
	import uvst_pkg::*;
#(
	parameter int IDX = 0,
	parameter int IW  = 4,
	parameter int CW  = 5
) (
	input  logic           clk,
	input  logic           arst_n,
	input  uvst_cell_ctl_t ctl,
	input  logic [31:0]    cmp_val,
	input  logic [31:0]    wr_val,
	input  logic [CW-1:0]  count,
	input  logic [IW-1:0]  pos,
	input  logic [31:0]    nbr_val,
	output logic [31:0]    val,
	output logic           hit
);

	localparam logic [CW-1:0] IDX_C = CW'(IDX);
	localparam logic [IW-1:0] IDX_P = IW'(IDX);

	logic [31:0] entry_q;
	logic        hit_q;
	logic        occupied;

	assign occupied = (IDX_C < count);
	assign val      = entry_q;
	assign hit      = hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.load) begin
			hit_q <= occupied && (entry_q == cmp_val);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.insert_en && (IDX_C == count)) begin
			entry_q <= wr_val;
		end else if (ctl.remove_en && (IDX_P >= pos)) begin
			entry_q <= nbr_val;
		end
	end

endmodule

// File: src/unique_value_set_table_top.sv
// ----------------------------------------------------------------------------
// unique_value_set_table_top
// Ordered set of distinct 32-bit values kept in a row of slot cells.
// Insert appends, remove closes the gap, query reports membership.
// ----------------------------------------------------------------------------
//  channel | signals                       | direction
//  --------+-------------------------------+----------
//  in      | in_valid, in_ready, in_data   | request in
//  out     | out_valid, out_ready, out_data| result out
//
// For each request, the edge that accepts it latches the compare of every
// slot; the commit then updates the table and loads the output
// register. A new request is taken once the previous one commits.
// A stalled output holds the pending request in the compare stage.
// Reset clears the count and the handshake state; slot contents stay as is.
module unique_value_set_table_top
	import uvst_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  uvst_req_t in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output uvst_rsp_t out_data
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	logic          s1_valid_q;
	logic [1:0]    kind_s1;
	logic [31:0]   value_s1;
	logic [CW-1:0] count_q;
	logic          out_valid_q;
	uvst_rsp_t     out_q;

	logic [CAPACITY-1:0] hit;
	logic [31:0]         cell_val [CAPACITY];
	logic [IW-1:0]       pos;
	logic                present;
	logic                accept;
	logic                done;
	logic [1:0]          status;
	logic [CW-1:0]       count_nxt;
	uvst_cell_ctl_t      ctl;
	logic [IW+3:0]       pos_ext;
	logic [CW+4:0]       cnt_ext;

	assign in_ready  = !s1_valid_q;
	assign accept    = in_valid && in_ready;
	assign done      = s1_valid_q && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// at most one slot can match, so the index is an OR of the hit slots
	always_comb begin
		pos = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (hit[i]) begin
				pos = pos | IW'(i);
			end
		end
	end
	assign present = |hit;

	always_comb begin
		status    = ST_DONE;
		count_nxt = count_q;
		ctl.load      = accept;
		ctl.insert_en = 1'b0;
		ctl.remove_en = 1'b0;
		case (kind_s1)
			KIND_INSERT: begin
				if (present) begin
					status = ST_IGNORED;
				end else if (count_q >= CAP_C) begin
					status = ST_FULL;
				end else begin
					count_nxt     = count_q + 1'b1;
					ctl.insert_en = done;
				end
			end
			KIND_REMOVE: begin
				if (present) begin
					count_nxt     = count_q - 1'b1;
					ctl.remove_en = done;
				end else begin
					status = ST_IGNORED;
				end
			end
			default: begin
				status = ST_DONE;
			end
		endcase
	end

	assign pos_ext = {4'b0, pos};
	assign cnt_ext = {5'b0, count_nxt};

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [31:0] nbr;
		if (g == CAPACITY - 1) begin : g_last
			assign nbr = cell_val[g];
		end else begin : g_mid
			assign nbr = cell_val[g+1];
		end
		uvst_cell #(
			.IDX(g),
			.IW (IW),
			.CW (CW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.cmp_val(in_data.value),
			.wr_val (value_s1),
			.count  (count_q),
			.pos    (pos),
			.nbr_val(nbr),
			.val    (cell_val[g]),
			.hit    (hit[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (done) begin
				s1_valid_q <= 1'b0;
			end
			if (done) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= in_data.kind;
			value_s1 <= in_data.value;
		end
		if (done) begin
			out_q.was_present <= present;
			out_q.position    <= pos_ext[3:0];
			out_q.status      <= status;
			out_q.entry_count <= cnt_ext[4:0];
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count above capacity");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> $onehot0(hit))
		else $error("value stored in more than one slot");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.insert_en |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow the table");

	a_remove_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.remove_en |=> count_q == $past(count_q) - 1'b1)
		else $error("remove did not shrink the table");

	a_done_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> out_valid_q && !s1_valid_q)
		else $error("committed request did not reach the output");

endmodule
